[rtl/core/wdc_pkg.sv]
// Shared types, constants and ramp coefficient tables for the waypoint drive controller.
`default_nettype none

package wdc_pkg;

   // Motion mode codes; the last code behaves as a turn in place.
   typedef enum logic [1:0] {
      MODE_FORWARD  = 2'd0,
      MODE_REVERSE  = 2'd1,
      MODE_TURN     = 2'd2,
      MODE_TURN_ALT = 2'd3
   } mode_type;

   // Register indexes on the configuration port (word addressed).
   typedef enum logic [2:0] {
      CSR_MOVE_MODE     = 3'd0,
      CSR_MAG_GAIN      = 3'd1,
      CSR_TURN_GAIN     = 3'd2,
      CSR_STRAIGHT_MAX  = 3'd3,
      CSR_STRAIGHT_MIN  = 3'd4,
      CSR_TURN_MAX      = 3'd5,
      CSR_TURN_MIN      = 3'd6,
      CSR_SLOW_DOWN     = 3'd7
   } csr_index_type;

   localparam int DIST_DEADBAND    = 8;
   localparam int HEAD_SLOW_ANGLE  = 40;
   localparam int STRAIGHT_RAMP_MS = 500;
   localparam int TURN_RAMP_MS     = 250;
   localparam int SETTLE_MS        = 500;
   localparam int HOLD_SPEED       = 10;

   // Ramp division by a constant is done as a multiply by a rounded-up
   // reciprocal that already includes the max speed. The shifts are large
   // enough that the result is exact for every elapsed time in the ramp.
   localparam int STRAIGHT_COEF_SHIFT = 18;
   localparam int TURN_COEF_SHIFT     = 16;
   localparam int SPEED_CODES         = 128;

   typedef logic [16:0] straight_coef_type;
   typedef logic [15:0] turn_coef_type;
   typedef straight_coef_type straight_coef_table_type [SPEED_CODES];
   typedef turn_coef_type     turn_coef_table_type     [SPEED_CODES];

   function automatic straight_coef_table_type straight_coef_table();
      straight_coef_table_type t;
      for (int i = 0; i < SPEED_CODES; i++) begin
         t[i] = 17'((i * (2 ** STRAIGHT_COEF_SHIFT) + STRAIGHT_RAMP_MS - 1) / STRAIGHT_RAMP_MS);
      end
      return t;
   endfunction

   function automatic turn_coef_table_type turn_coef_table();
      turn_coef_table_type t;
      for (int i = 0; i < SPEED_CODES; i++) begin
         t[i] = 16'((i * (2 ** TURN_COEF_SHIFT) + TURN_RAMP_MS - 1) / TURN_RAMP_MS);
      end
      return t;
   endfunction

   localparam straight_coef_table_type STRAIGHT_COEF = straight_coef_table();
   localparam turn_coef_table_type     TURN_COEF     = turn_coef_table();

   // Current configuration as seen by the datapath.
   typedef struct packed {
      mode_type          mode;
      logic [7:0]        mag_gain;
      logic [7:0]        turn_gain;
      logic [6:0]        straight_max;
      logic [6:0]        straight_min;
      logic [6:0]        turn_max;
      logic [6:0]        turn_min;
      logic [11:0]       slow_dist;
      straight_coef_type straight_coef;
      turn_coef_type     turn_coef;
   } cfg_type;

   // Target flags; distance is sticky, heading is sticky except in the turn modes.
   typedef struct packed {
      logic dist_reached;
      logic head_reached;
   } flags_type;

endpackage

`default_nettype wire

[rtl/core/waypoint_drive_controller_unit.sv]
// Top level of the waypoint drive controller: handshake stages, registers, law and settle logic.
`default_nettype none

// Channel   Direction  Beat contents
// req_*     in         distance_error, heading_error, elapsed_ms, now_ms (one control tick)
// rsp_*     out        drive_magnitude, drive_rotation, move_finished (one per tick)
// csr_*     in/out     APB-style access to the eight configuration registers
//
// Every tick passes from request to response through the input register,
// then one pass through the drive law and settle logic into the
// response register. One beat can enter every cycle while req_stall is low.
// Synchronous active-high reset restores the configuration defaults and clears
// the sticky flags, the settle timers and both stage valids.
// req_stall rises only when both stages hold a beat and rsp_stall is high.

module waypoint_drive_controller_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic signed [15:0] req_distance_error,
   input  wire logic signed [10:0] req_heading_error,
   input  wire logic [15:0]        req_elapsed_ms,
   input  wire logic [31:0]        req_now_ms,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic signed [7:0]  rsp_drive_magnitude,
   output      logic signed [7:0]  rsp_drive_rotation,
   output      logic               rsp_move_finished,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [4:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output      logic [31:0]        csr_prdata,
   output      logic               csr_pready
);

   wdc_pkg::cfg_type   cfg;
   wdc_pkg::flags_type flags_cur;
   wdc_pkg::flags_type flags_nxt;

   // Input stage.
   logic               in_valid_ff;
   logic               in_valid_in;
   logic signed [15:0] in_dist_ff;
   logic signed [10:0] in_head_ff;
   logic [15:0]        in_elapsed_ff;
   logic [31:0]        in_now_ff;

   // Response stage.
   logic               out_valid_ff;
   logic               out_valid_in;
   logic signed [7:0]  out_mag_ff;
   logic signed [7:0]  out_rot_ff;
   logic               out_fin_ff;

   logic               req_take;
   logic               advance;
   logic               finished;
   logic signed [7:0]  law_mag;
   logic signed [7:0]  law_rot;

   // The input beat moves on whenever the response register is free or
   // being emptied in the same cycle; state is updated at that moment so
   // ticks see each other's flags in order.
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   assign rsp_valid           = out_valid_ff;
   assign rsp_drive_magnitude = out_mag_ff;
   assign rsp_drive_rotation  = out_rot_ff;
   assign rsp_move_finished   = out_fin_ff;

   wdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wdc_datapath u_datapath (
      .cfg             (cfg),
      .distance_error  (in_dist_ff),
      .heading_error   (in_head_ff),
      .elapsed_ms      (in_elapsed_ff),
      .flags_cur       (flags_cur),
      .drive_magnitude (law_mag),
      .drive_rotation  (law_rot),
      .flags_nxt       (flags_nxt)
   );

   wdc_settle u_settle (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .now_ms    (in_now_ff),
      .flags_nxt (flags_nxt),
      .flags_cur (flags_cur),
      .finished  (finished)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load on their enables only and need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_dist_ff    <= req_distance_error;
         in_head_ff    <= req_heading_error;
         in_elapsed_ff <= req_elapsed_ms;
         in_now_ff     <= req_now_ms;
      end
      if (advance) begin
         out_mag_ff <= finished ? 8'sd0 : law_mag;
         out_rot_ff <= finished ? 8'sd0 : law_rot;
         out_fin_ff <= finished;
      end
   end

   // A finished move drives nothing.
   a_fin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_move_finished |-> rsp_drive_magnitude == 8'sd0 &&
                                         rsp_drive_rotation == 8'sd0)
      else $error("finished beat carries a nonzero drive");

   // The clamp keeps the magnitude inside the symmetric range.
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive_magnitude != -8'sd128)
      else $error("drive magnitude outside clamp range");

   // Turn in place never commands forward drive.
   a_turn_no_mag: assert property (@(posedge clock) disable iff (reset)
      advance && (cfg.mode == wdc_pkg::MODE_TURN || cfg.mode == wdc_pkg::MODE_TURN_ALT)
         |-> law_mag == 8'sd0)
      else $error("turn mode produced forward drive");

   // Backpressure only appears with a beat parked in the input stage.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with an empty input stage");

   // A beat that leaves the input stage shows up as a response.
   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced beat lost before the response register");

endmodule

`default_nettype wire

[rtl/core/wdc_csr.sv]
// Configuration registers with APB-style access and precomputed ramp coefficients.
`default_nettype none

module wdc_csr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [4:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output      logic [31:0]         csr_prdata,
   output      logic                csr_pready,
   output      wdc_pkg::cfg_type    cfg
);

   localparam logic [7:0]  RST_MAG_GAIN     = 8'd32;
   localparam logic [7:0]  RST_TURN_GAIN    = 8'd32;
   localparam logic [6:0]  RST_STRAIGHT_MAX = 7'd100;
   localparam logic [6:0]  RST_STRAIGHT_MIN = 7'd20;
   localparam logic [6:0]  RST_TURN_MAX     = 7'd80;
   localparam logic [6:0]  RST_TURN_MIN     = 7'd25;
   localparam logic [11:0] RST_SLOW_DIST    = 12'd288;

   wdc_pkg::cfg_type       cfg_ff;
   wdc_pkg::cfg_type       cfg_in;
   wdc_pkg::csr_index_type index;
   logic                   wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign index      = wdc_pkg::csr_index_type'(csr_paddr[4:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            wdc_pkg::CSR_MOVE_MODE:    cfg_in.mode = wdc_pkg::mode_type'(csr_pwdata[1:0]);
            wdc_pkg::CSR_MAG_GAIN:     cfg_in.mag_gain = csr_pwdata[7:0];
            wdc_pkg::CSR_TURN_GAIN:    cfg_in.turn_gain = csr_pwdata[7:0];
            wdc_pkg::CSR_STRAIGHT_MAX: begin
               cfg_in.straight_max  = csr_pwdata[6:0];
               cfg_in.straight_coef = wdc_pkg::STRAIGHT_COEF[csr_pwdata[6:0]];
            end
            wdc_pkg::CSR_STRAIGHT_MIN: cfg_in.straight_min = csr_pwdata[6:0];
            wdc_pkg::CSR_TURN_MAX: begin
               cfg_in.turn_max  = csr_pwdata[6:0];
               cfg_in.turn_coef = wdc_pkg::TURN_COEF[csr_pwdata[6:0]];
            end
            wdc_pkg::CSR_TURN_MIN:     cfg_in.turn_min = csr_pwdata[6:0];
            wdc_pkg::CSR_SLOW_DOWN:    cfg_in.slow_dist = csr_pwdata[11:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         wdc_pkg::CSR_MOVE_MODE:    csr_prdata = {30'd0, cfg_ff.mode};
         wdc_pkg::CSR_MAG_GAIN:     csr_prdata = {24'd0, cfg_ff.mag_gain};
         wdc_pkg::CSR_TURN_GAIN:    csr_prdata = {24'd0, cfg_ff.turn_gain};
         wdc_pkg::CSR_STRAIGHT_MAX: csr_prdata = {25'd0, cfg_ff.straight_max};
         wdc_pkg::CSR_STRAIGHT_MIN: csr_prdata = {25'd0, cfg_ff.straight_min};
         wdc_pkg::CSR_TURN_MAX:     csr_prdata = {25'd0, cfg_ff.turn_max};
         wdc_pkg::CSR_TURN_MIN:     csr_prdata = {25'd0, cfg_ff.turn_min};
         wdc_pkg::CSR_SLOW_DOWN:    csr_prdata = {20'd0, cfg_ff.slow_dist};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= wdc_pkg::MODE_FORWARD;
         cfg_ff.mag_gain      <= RST_MAG_GAIN;
         cfg_ff.turn_gain     <= RST_TURN_GAIN;
         cfg_ff.straight_max  <= RST_STRAIGHT_MAX;
         cfg_ff.straight_min  <= RST_STRAIGHT_MIN;
         cfg_ff.turn_max      <= RST_TURN_MAX;
         cfg_ff.turn_min      <= RST_TURN_MIN;
         cfg_ff.slow_dist     <= RST_SLOW_DIST;
         cfg_ff.straight_coef <= wdc_pkg::STRAIGHT_COEF[RST_STRAIGHT_MAX];
         cfg_ff.turn_coef     <= wdc_pkg::TURN_COEF[RST_TURN_MAX];
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/wdc_datapath.sv]
// Combinational drive law: proportional, ramp and full-speed regions for distance and heading.
`default_nettype none

module wdc_datapath (
   input  wire wdc_pkg::cfg_type   cfg,
   input  wire logic signed [15:0] distance_error,
   input  wire logic signed [10:0] heading_error,
   input  wire logic [15:0]        elapsed_ms,
   input  wire wdc_pkg::flags_type flags_cur,
   output      logic signed [7:0]  drive_magnitude,
   output      logic signed [7:0]  drive_rotation,
   output      wdc_pkg::flags_type flags_nxt
);

   // Offset, clamp and sign of a proportional term.
   function automatic logic signed [7:0] prop_drive(input logic positive,
                                                    input logic [11:0] term,
                                                    input logic [6:0] min_speed,
                                                    input logic [6:0] max_speed);
      logic [12:0] sum;
      logic [6:0]  lim;
      sum = 13'(term) + 13'(min_speed);
      if (sum > 13'(max_speed)) begin
         lim = max_speed;
      end else begin
         lim = sum[6:0];
      end
      return positive ? $signed({1'b0, lim}) : -$signed({1'b0, lim});
   endfunction

   function automatic logic signed [7:0] signed_drive(input logic negate,
                                                      input logic [6:0] speed);
      return negate ? -$signed({1'b0, speed}) : $signed({1'b0, speed});
   endfunction

   logic [15:0] dist_abs;
   logic [10:0] head_abs;
   logic        dist_near;
   logic        dist_slow;
   logic        straight_ramp;
   logic        turn_ramp;
   logic        head_hold;
   logic        head_slow;
   logic        reverse;
   logic        head_neg;
   logic [19:0] dist_prod;
   logic [13:0] turn_prod;
   logic [25:0] straight_ramp_prod;
   logic [23:0] turn_ramp_prod;
   logic [11:0] dist_term;
   logic [11:0] head_straight_term;
   logic [11:0] head_turn_term;
   logic [6:0]  straight_ramp_speed;
   logic [6:0]  turn_ramp_speed;

   assign dist_abs = distance_error[15] ? 16'(-distance_error) : 16'(distance_error);
   assign head_abs = heading_error[10] ? 11'(-heading_error) : 11'(heading_error);
   assign head_neg = heading_error[10];
   assign reverse  = (cfg.mode == wdc_pkg::MODE_REVERSE);

   assign dist_near     = dist_abs < 16'(wdc_pkg::DIST_DEADBAND);
   assign dist_slow     = dist_abs < {4'd0, cfg.slow_dist};
   assign straight_ramp = elapsed_ms < 16'(wdc_pkg::STRAIGHT_RAMP_MS);
   assign turn_ramp     = elapsed_ms < 16'(wdc_pkg::TURN_RAMP_MS);
   assign head_hold     = head_abs <= 11'd1;
   assign head_slow     = head_abs < 11'(wdc_pkg::HEAD_SLOW_ANGLE);

   // Each product is only selected when its operand is known to be narrow.
   assign dist_prod          = 20'(dist_abs[11:0]) * 20'(cfg.mag_gain);
   assign dist_term          = dist_prod[19:8];
   assign head_straight_term = 12'(head_abs[10:1]);
   assign turn_prod          = 14'(head_abs[5:0]) * 14'(cfg.turn_gain);
   assign head_turn_term     = 12'(turn_prod[13:4]);

   assign straight_ramp_prod  = 26'(elapsed_ms[8:0]) * 26'(cfg.straight_coef);
   assign straight_ramp_speed = straight_ramp_prod[wdc_pkg::STRAIGHT_COEF_SHIFT +: 7];
   assign turn_ramp_prod      = 24'(elapsed_ms[7:0]) * 24'(cfg.turn_coef);
   assign turn_ramp_speed     = turn_ramp_prod[wdc_pkg::TURN_COEF_SHIFT +: 7];

   always_comb begin
      drive_magnitude = '0;
      drive_rotation  = '0;
      flags_nxt       = flags_cur;
      unique case (cfg.mode)
         wdc_pkg::MODE_FORWARD, wdc_pkg::MODE_REVERSE: begin
            if (dist_near) begin
               flags_nxt.dist_reached = 1'b1;
            end else begin
               if (head_abs != 11'd0) begin
                  drive_rotation = prop_drive(!head_neg, head_straight_term,
                                              cfg.turn_min, cfg.turn_max);
               end
               priority if (dist_slow) begin
                  drive_magnitude = prop_drive(!distance_error[15], dist_term,
                                               cfg.straight_min, cfg.straight_max);
               end else if (straight_ramp) begin
                  drive_magnitude = signed_drive(reverse, straight_ramp_speed);
               end else begin
                  drive_magnitude = signed_drive(reverse, cfg.straight_max);
               end
            end
            // Once the distance target is held, magnitude is zeroed and heading counts as reached.
            if (flags_nxt.dist_reached) begin
               drive_magnitude        = '0;
               flags_nxt.head_reached = 1'b1;
            end
         end
         wdc_pkg::MODE_TURN, wdc_pkg::MODE_TURN_ALT: begin
            flags_nxt.dist_reached = 1'b1;
            flags_nxt.head_reached = head_hold;
            priority if (head_hold) begin
               drive_rotation = signed_drive(!head_neg, 7'(wdc_pkg::HOLD_SPEED));
            end else if (head_slow) begin
               drive_rotation = prop_drive(!head_neg, head_turn_term,
                                           cfg.turn_min, cfg.turn_max);
            end else if (turn_ramp) begin
               drive_rotation = signed_drive(head_neg, turn_ramp_speed);
            end else begin
               drive_rotation = signed_drive(head_neg, cfg.turn_max);
            end
         end
         default: begin
            drive_magnitude = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/wdc_settle.sv]
// Target flags (sticky but for heading in the turn modes) and settle timers that decide when a move is finished.
`default_nettype none

module wdc_settle (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic [31:0]        now_ms,
   input  wire wdc_pkg::flags_type flags_nxt,
   output      wdc_pkg::flags_type flags_cur,
   output      logic               finished
);

   wdc_pkg::flags_type flags_ff;
   logic               dist_armed_ff;
   logic               head_armed_ff;
   logic [31:0]        dist_start_ff;
   logic [31:0]        head_start_ff;
   logic [31:0]        dist_start_in;
   logic [31:0]        head_start_in;
   logic [31:0]        dist_age;
   logic [31:0]        head_age;

   assign flags_cur = flags_ff;

   // A clear flag disarms its timer; a newly set flag stamps the current time.
   assign dist_start_in = !flags_nxt.dist_reached ? 32'd0 :
                          (dist_armed_ff ? dist_start_ff : now_ms);
   assign head_start_in = !flags_nxt.head_reached ? 32'd0 :
                          (head_armed_ff ? head_start_ff : now_ms);

   assign dist_age = now_ms - dist_start_in;
   assign head_age = now_ms - head_start_in;

   assign finished = flags_nxt.dist_reached && flags_nxt.head_reached &&
                     (dist_age > 32'(wdc_pkg::SETTLE_MS)) &&
                     (head_age > 32'(wdc_pkg::SETTLE_MS));

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff      <= '0;
         dist_armed_ff <= 1'b0;
         head_armed_ff <= 1'b0;
         dist_start_ff <= '0;
         head_start_ff <= '0;
      end else if (advance) begin
         flags_ff      <= flags_nxt;
         dist_armed_ff <= flags_nxt.dist_reached;
         head_armed_ff <= flags_nxt.head_reached;
         dist_start_ff <= dist_start_in;
         head_start_ff <= head_start_in;
      end
   end

endmodule

`default_nettype wire
